@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the key intern table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define KIH_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KIH_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/kih_pkg.sv @@
// Package: payload types, op and status codes, state enum, FNV basis and step function.
`timescale 1ns / 1ps
package kih_pkg;

   typedef enum logic [1:0] {
      OP_INTERN = 2'd0,
      OP_FIND   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_REFED    = 3'd1,
      ST_FOUND    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_TOOLONG  = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_MOD,
      BK_MODSUB,
      BK_READ,
      BK_CMP,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] key_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  slot;
      logic [31:0] use_count;
      logic [8:0]  entry_count;
      logic [63:0] key_hash;
   } rsp_type;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [31:0] REF_MAX   = 32'hFFFFFFFF;

   // One FNV-1a round; the prime is 2^40 + 0x1B3.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x * 64'h1B3);
   endfunction

endpackage

@@ src/kih_queue.sv @@
// Two-word queue between the front and the back.
`timescale 1ns / 1ps
module kih_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);
   logic [WIDTH-1:0] data_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   // Advance pointers and count.
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store pushed word.
   always_ff @(posedge clock) begin
      if (push) data_ff[wp_ff] <= push_data;
   end

   assign head  = data_ff[rp_ff];
   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
endmodule

@@ src/kih_front.sv @@
// Front: hash key bytes, buffer the key, queue a command on the last word.
`timescale 1ns / 1ps
module kih_front #(
   parameter int MAX_KEY_BYTES = 32,
   parameter int LEN_W = 6,
   parameter int CMD_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  kih_pkg::req_type  req,
   output logic              push,
   output logic [CMD_W-1:0]  cmd
);
   import kih_pkg::*;

   typedef struct packed {
      logic [1:0]                   op;
      logic [63:0]                  hash;
      logic [LEN_W-1:0]             len;
      logic                         over;
      logic [MAX_KEY_BYTES*8-1:0]   key;
   } cmd_type;

   logic [63:0]      hash_ff, hash_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             over_ff, over_in;
   logic [7:0]       keybuf_ff [MAX_KEY_BYTES];
   logic             store;
   cmd_type          cmd_d;

   // Fold the byte and extend the key.
   always_comb begin
      store   = accept && req.byte_valid && (len_ff < LEN_W'(MAX_KEY_BYTES));
      hash_in = hash_ff;
      len_in  = len_ff;
      over_in = over_ff;
      if (accept && req.byte_valid) begin
         hash_in = fnv_step(hash_ff, req.key_byte);
         if (store) len_in = len_ff + 1'b1;
         else over_in = 1'b1;
      end
      cmd_d.op   = req.op;
      cmd_d.hash = hash_in;
      cmd_d.len  = len_in;
      cmd_d.over = over_in;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         cmd_d.key[i*8 +: 8] = (store && LEN_W'(i) == len_ff) ? req.key_byte : keybuf_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         len_ff  <= '0;
         over_ff <= 1'b0;
      end else if (accept && req.last) begin
         hash_ff <= FNV_BASIS;
         len_ff  <= '0;
         over_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
         over_ff <= over_in;
      end
   end

   // Buffer the stored byte.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (store && LEN_W'(i) == len_ff) keybuf_ff[i] <= req.key_byte;
      end
   end

   assign push = accept && req.last;
   assign cmd  = cmd_d;
endmodule

@@ src/kih_back.sv @@
// Back: probe the slot table, update entries, sweep on clear, drive results.
`timescale 1ns / 1ps
module kih_back #(
   parameter int SLOTS = 256,
   parameter int MAX_KEY_BYTES = 32,
   parameter int LEN_W = 6,
   parameter int CMD_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  logic [CMD_W-1:0]  cmd,
   output logic              cmd_pop,
   output logic              init_busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kih_pkg::rsp_type  rsp
);
   import kih_pkg::*;

   localparam int  SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int  CW = $clog2(SLOTS + 1);
   localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
   // Reciprocal of SLOTS scaled by 2^24 for the per-byte remainder step.
   localparam logic [23:0] MOD_K = 24'((64'd1 << 24) / SLOTS);

   typedef struct packed {
      logic [1:0]                 op;
      logic [63:0]                hash;
      logic [LEN_W-1:0]           len;
      logic                       over;
      logic [MAX_KEY_BYTES*8-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic                       occ;
      logic [63:0]                hash;
      logic [LEN_W-1:0]           len;
      logic [31:0]                refs;
      logic [MAX_KEY_BYTES*8-1:0] key;
   } row_type;

   typedef struct packed {
      logic [2:0]    status;
      logic [SW-1:0] slot;
      logic [31:0]   refs;
   } res_type;

   back_state_type state_ff, state_in;
   cmd_type        cmd_d, cmd_ff, cmd_in;
   logic [SW-1:0]  slot_ff, slot_in, slot_nxt;
   logic [SW-1:0]  probe_ff, probe_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [2:0]     idx_ff, idx_in;
   logic [23:0]    mod_v, mod_q_ff, mod_q_in, mod_r;
   logic [CW-1:0]  count_ff, count_in;
   res_type        res_ff, res_in;
   row_type        mem [SLOTS];
   row_type        rd_ff, wd;
   logic           we, re, match, last_slot;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in, load;

   assign cmd_d     = cmd;
   assign last_slot = (slot_ff == SW'(SLOTS - 1));
   assign slot_nxt  = last_slot ? '0 : slot_ff + 1'b1;

   // Fold one hash byte into the remainder: estimate quotient, then subtract.
   assign mod_v    = {16'(rem_ff), cmd_ff.hash[{idx_ff, 3'b000} +: 8]};
   assign mod_q_in = 24'((48'(mod_v) * 48'(MOD_K)) >> 24);
   assign mod_r    = mod_v - mod_q_ff * 24'(SLOTS);

   // Compare the stored key with the probe key.
   always_comb begin
      match = (rd_ff.hash == cmd_ff.hash) && (rd_ff.len == cmd_ff.len);
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (LEN_W'(i) < cmd_ff.len && rd_ff.key[i*8 +: 8] != cmd_ff.key[i*8 +: 8])
            match = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_INIT: if (last_slot) state_in = BK_IDLE;
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd_d.op == OP_CLEAR) state_in = BK_INIT;
               else if (cmd_d.over) state_in = BK_RESP;
               else if (IS_POW2) state_in = BK_READ;
               else state_in = BK_MOD;
            end
         end
         BK_MOD:    state_in = BK_MODSUB;
         BK_MODSUB: state_in = (idx_ff == 3'd0) ? BK_READ : BK_MOD;
         BK_READ:   state_in = BK_CMP;
         BK_CMP: begin
            if (!rd_ff.occ || match || probe_ff == SW'(SLOTS - 1)) state_in = BK_RESP;
            else state_in = BK_READ;
         end
         BK_RESP: if (!rsp_valid_ff || !rsp_stall) state_in = BK_IDLE;
         default: state_in = BK_INIT;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      probe_in = probe_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      res_in   = res_ff;
      cmd_pop  = 1'b0;
      we       = 1'b0;
      re       = 1'b0;
      wd       = '0;
      load     = 1'b0;
      unique case (state_ff)
         BK_INIT: begin
            we      = 1'b1;
            slot_in = slot_nxt;
         end
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_d;
               slot_in  = (IS_POW2 && cmd_d.op != OP_CLEAR) ? cmd_d.hash[SW-1:0] : '0;
               probe_in = '0;
               rem_in   = '0;
               idx_in   = 3'd7;
               res_in.status = (cmd_d.op == OP_INTERN) ? ST_TOOLONG : ST_NOTFOUND;
               res_in.slot   = '0;
               res_in.refs   = '0;
               if (cmd_d.op == OP_CLEAR) count_in = '0;
            end
         end
         BK_MOD: ;
         BK_MODSUB: begin
            rem_in = (mod_r >= 24'(SLOTS)) ? SW'(mod_r - 24'(SLOTS)) : SW'(mod_r);
            idx_in = idx_ff - 1'b1;
            if (idx_ff == 3'd0) slot_in = rem_in;
         end
         BK_READ: re = 1'b1;
         BK_CMP: begin
            wd = rd_ff;
            if (!rd_ff.occ) begin
               if (cmd_ff.op == OP_INTERN) begin
                  we       = 1'b1;
                  wd.occ   = 1'b1;
                  wd.hash  = cmd_ff.hash;
                  wd.len   = cmd_ff.len;
                  wd.refs  = 32'd1;
                  wd.key   = cmd_ff.key;
                  count_in = count_ff + 1'b1;
                  res_in   = '{status: ST_INSERTED, slot: slot_ff, refs: 32'd1};
               end else begin
                  res_in   = '{status: ST_NOTFOUND, slot: '0, refs: '0};
               end
            end else if (match) begin
               if (cmd_ff.op == OP_INTERN) begin
                  we = 1'b1;
                  if (rd_ff.refs != REF_MAX) wd.refs = rd_ff.refs + 1'b1;
                  res_in = '{status: ST_REFED, slot: slot_ff, refs: wd.refs};
               end else begin
                  res_in = '{status: ST_FOUND, slot: slot_ff, refs: rd_ff.refs};
               end
            end else begin
               slot_in  = slot_nxt;
               probe_in = probe_ff + 1'b1;
               res_in.status = (cmd_ff.op == OP_INTERN) ? ST_FULL : ST_NOTFOUND;
               res_in.slot   = '0;
               res_in.refs   = '0;
            end
         end
         BK_RESP: load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
      rsp_in.status      = res_ff.status;
      rsp_in.slot        = 8'(res_ff.slot);
      rsp_in.use_count   = res_ff.refs;
      rsp_in.entry_count = 9'(count_ff);
      rsp_in.key_hash    = cmd_ff.hash;
      if (load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         slot_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      probe_ff <= probe_in;
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      mod_q_ff <= mod_q_in;
      res_ff   <= res_in;
      if (load) rsp_ff <= rsp_in;
   end

   // Slot table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) mem[slot_ff] <= wd;
      if (re) rd_ff <= mem[slot_ff];
   end

   assign init_busy = (state_ff == BK_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule

@@ src/key_intern_hash_table.sv @@
// Top level: key intern hash table with decoupled hashing front and probing back.
//
//   port group   direction  meaning
//   req_*        in         one key byte word per handshake, op on the last word
//   rsp_*        out        one result word per command other than clear
//
// Key bytes are taken one per cycle; outside a sweep only a full command queue
// stalls intake. Each command then probes slots, each by a registered table read
// and a compare, after a hash mod SLOTS (estimate and subtract per hash byte) when
// SLOTS is not a power of two, and then posts the result.
// After reset, and for each clear, the back sweeps all SLOTS rows, one per cycle;
// req_stall is high during every sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module key_intern_hash_table #(
   parameter int SLOTS = 256,
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kih_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kih_pkg::rsp_type rsp
);
   import kih_pkg::*;

   localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int CMD_W = 2 + 64 + LEN_W + 1 + MAX_KEY_BYTES * 8;

   logic             accept, q_push, q_pop, q_empty, q_full, init_busy;
   logic [CMD_W-1:0] q_in, q_head;
   logic             rsp_ins, rsp_miss, rsp_zero;

   assign req_stall = q_full || init_busy;
   assign accept    = req_valid && !req_stall;

   kih_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES), .LEN_W(LEN_W), .CMD_W(CMD_W)) u_front (
      .clock (clock), .reset (reset), .accept (accept), .req (req),
      .push (q_push), .cmd (q_in)
   );

   kih_queue #(.WIDTH(CMD_W)) u_queue (
      .clock (clock), .reset (reset), .push (q_push), .push_data (q_in),
      .pop (q_pop), .head (q_head), .empty (q_empty), .full (q_full)
   );

   kih_back #(.SLOTS(SLOTS), .MAX_KEY_BYTES(MAX_KEY_BYTES), .LEN_W(LEN_W),
              .CMD_W(CMD_W)) u_back (
      .clock (clock), .reset (reset), .cmd_valid (!q_empty), .cmd (q_head),
      .cmd_pop (q_pop), .init_busy (init_busy), .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall), .rsp (rsp)
   );

   // Classify the result word for the checks below.
   assign rsp_ins  = rsp_valid && (rsp.status == ST_INSERTED);
   assign rsp_miss = rsp_valid && (rsp.status == ST_NOTFOUND || rsp.status == ST_TOOLONG ||
                                   rsp.status == ST_FULL);
   assign rsp_zero = (rsp.slot == 8'd0) && (rsp.use_count == 32'd0);

   `KIH_ASSERT(a_no_overflow, clock, reset, q_push |-> !q_full, "queue overflow")
   `KIH_ASSERT(a_no_underflow, clock, reset, q_pop |-> !q_empty, "queue underflow")
   `KIH_ASSERT(a_insert_one, clock, reset, rsp_ins |-> (rsp.use_count == 32'd1), "insert count")
   `KIH_ASSERT(a_miss_zero, clock, reset, rsp_miss |-> rsp_zero, "miss fields not zero")
endmodule

@@ test/tb_key_intern_hash_table.sv @@
// Self-checking testbench for the key intern hash table: directed and random key streams.
`timescale 1ns / 1ps
module tb_key_intern_hash_table;
   import kih_pkg::*;

   localparam int          NSLOTS     = 256;
   localparam int          KEY_MAX    = 32;
   localparam logic [63:0] HASH_MULT  = 64'd1099511628211;
   localparam logic [31:0] COUNT_MAX  = 32'hFFFFFFFF;
   localparam int          CYCLE_CAP  = 6000000;
   localparam int          SETTLE     = 700;
   localparam int          RAND_WORDS = 360;
   localparam int          POOL       = 32;
   localparam int          POOL_LEN   = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   key_intern_hash_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   // key being built by the shadow table
   logic [63:0] key_hash_acc;
   int          key_len;
   bit          key_long;
   logic [7:0]  key_buf [KEY_MAX];

   // shadow table contents
   bit          tbl_used  [NSLOTS];
   logic [63:0] tbl_hash  [NSLOTS];
   int          tbl_len   [NSLOTS];
   logic [7:0]  tbl_bytes [NSLOTS][KEY_MAX];
   logic [31:0] tbl_refs  [NSLOTS];
   int          tbl_count;

   rsp_type     pending_rsp [$];
   logic [7:0]  cur_key [$];
   logic [7:0]  pool_bytes [POOL][POOL_LEN];
   int          pool_len [POOL];

   int send_idle, recv_idle;
   int cycles = 0;
   int words_sent, results_seen, mismatches, clears_sent;
   int status_seen [8];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb_key_intern_hash_table: FAIL");
         $finish;
      end
   end

   function automatic bit key_matches(int s);
      if (tbl_hash[s] != key_hash_acc || tbl_len[s] != key_len) return 1'b0;
      for (int i = 0; i < key_len; i++)
         if (tbl_bytes[s][i] != key_buf[i]) return 1'b0;
      return 1'b1;
   endfunction

   // advance the shadow table by one accepted word, queue any result it causes
   task automatic predict_lookup(input req_type w);
      rsp_type r;
      int      s;
      bit      done;
      if (w.byte_valid) begin
         key_hash_acc = (key_hash_acc ^ {56'd0, w.key_byte}) * HASH_MULT;
         if (key_len < KEY_MAX) begin
            key_buf[key_len] = w.key_byte;
            key_len++;
         end else begin
            key_long = 1'b1;
         end
      end
      if (!w.last) return;
      if (w.op == OP_CLEAR) begin
         for (int i = 0; i < NSLOTS; i++) tbl_used[i] = 1'b0;
         tbl_count = 0;
      end else begin
         r = '0;
         r.status = ST_NOTFOUND;
         r.key_hash = key_hash_acc;
         if (key_long) begin
            r.status = (w.op == OP_INTERN) ? ST_TOOLONG : ST_NOTFOUND;
         end else begin
            s = int'(key_hash_acc[7:0]);
            done = 1'b0;
            for (int n = 0; n < NSLOTS && !done; n++) begin
               if (!tbl_used[s]) begin
                  if (w.op == OP_INTERN) begin
                     tbl_used[s] = 1'b1;
                     tbl_hash[s] = key_hash_acc;
                     tbl_len[s] = key_len;
                     for (int i = 0; i < key_len; i++) tbl_bytes[s][i] = key_buf[i];
                     tbl_refs[s] = 32'd1;
                     tbl_count++;
                     r.status = ST_INSERTED;
                     r.slot = s[7:0];
                     r.use_count = 32'd1;
                  end
                  done = 1'b1;
               end else if (key_matches(s)) begin
                  if (w.op == OP_INTERN) begin
                     if (tbl_refs[s] < COUNT_MAX) tbl_refs[s]++;
                     r.status = ST_REFED;
                  end else begin
                     r.status = ST_FOUND;
                  end
                  r.slot = s[7:0];
                  r.use_count = tbl_refs[s];
                  done = 1'b1;
               end
               s = (s + 1) % NSLOTS;
            end
            if (!done && w.op == OP_INTERN) r.status = ST_FULL;
         end
         r.entry_count = tbl_count[8:0];
         pending_rsp.push_back(r);
      end
      key_hash_acc = FNV_BASIS;
      key_len = 0;
      key_long = 1'b0;
   endtask

   // send one word, with random idle cycles ahead of it
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lookup(w);
      words_sent++;
      if (w.last && w.op == OP_CLEAR) clears_sent++;
   endtask

   // send cur_key as one command; noise adds empty words and a separate last word
   task automatic send_command(input logic [1:0] op, input int noise_pct);
      req_type w;
      bit      trail;
      trail = (cur_key.size() == 0) || ($urandom_range(99) < noise_pct);
      for (int i = 0; i < cur_key.size(); i++) begin
         while ($urandom_range(99) < noise_pct) begin
            w.op = 2'($urandom_range(3));
            w.key_byte = 8'($urandom);
            w.byte_valid = 1'b0;
            w.last = 1'b0;
            send_word(w);
         end
         w.op = (i == cur_key.size() - 1 && !trail) ? op : 2'($urandom_range(3));
         w.key_byte = cur_key[i];
         w.byte_valid = 1'b1;
         w.last = (i == cur_key.size() - 1) && !trail;
         send_word(w);
      end
      if (trail) begin
         w.op = op;
         w.key_byte = 8'($urandom);
         w.byte_valid = 1'b0;
         w.last = 1'b1;
         send_word(w);
      end
   endtask

   // drop valid and wait until every predicted result has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // compare each accepted result with the oldest prediction, randomize stall
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word %h", rsp);
            end else begin
               exp_rsp = pending_rsp.pop_front();
               status_seen[exp_rsp.status]++;
               if (rsp.status !== exp_rsp.status || rsp.slot !== exp_rsp.slot ||
                   rsp.use_count !== exp_rsp.use_count ||
                   rsp.entry_count !== exp_rsp.entry_count ||
                   rsp.key_hash !== exp_rsp.key_hash) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected st=%0d slot=%0d ref=%0d ent=%0d h=%h, got st=%0d slot=%0d ref=%0d ent=%0d h=%h",
                        exp_rsp.status, exp_rsp.slot, exp_rsp.use_count,
                        exp_rsp.entry_count, exp_rsp.key_hash, rsp.status, rsp.slot,
                        rsp.use_count, rsp.entry_count, rsp.key_hash);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // edge lengths and bytes, refs, misses, empty key, overlong, undefined op, clear
   task automatic test_directed();
      cur_key = {};
      send_command(OP_INTERN, 0);
      send_command(OP_FIND, 0);
      cur_key = {8'h61};
      send_command(OP_INTERN, 0);
      send_command(OP_INTERN, 30);
      send_command(OP_FIND, 0);
      send_command(OP_RSVD, 0);
      cur_key = {8'h62};
      send_command(OP_FIND, 0);
      cur_key = {};
      for (int i = 0; i < KEY_MAX; i++) cur_key.push_back(i[0] ? 8'hFF : 8'h00);
      send_command(OP_INTERN, 20);
      send_command(OP_FIND, 0);
      cur_key.push_back(8'h55);
      send_command(OP_INTERN, 0);
      send_command(OP_FIND, 0);
      cur_key = {8'h61};
      send_command(OP_CLEAR, 0);
      send_command(OP_FIND, 0);
   endtask

   // fill every slot, then hit the full table and a full-lap miss
   task automatic test_full_table();
      for (int i = 0; i < NSLOTS; i++) begin
         cur_key = {8'(i), 8'h5A};
         send_command(OP_INTERN, 0);
      end
      cur_key = {8'h00, 8'h00, 8'h01};
      send_command(OP_INTERN, 0);
      send_command(OP_FIND, 0);
      cur_key = {8'h03, 8'h5A};
      send_command(OP_INTERN, 0);
      send_command(OP_FIND, 0);
      wait_drained();
      cur_key = {};
      send_command(OP_CLEAR, 0);
   endtask

   // random commands drawn mostly from a key pool so that hits and refs happen
   task automatic test_random(input int word_goal);
      int          pick, roll;
      logic [1:0]  op;
      while (words_sent < word_goal) begin
         cur_key = {};
         roll = $urandom_range(99);
         if (roll < 85) begin
            pick = $urandom_range(POOL - 1);
            for (int i = 0; i < pool_len[pick]; i++) cur_key.push_back(pool_bytes[pick][i]);
         end else begin
            repeat ($urandom_range(36)) cur_key.push_back(8'($urandom));
         end
         roll = $urandom_range(99);
         if (roll < 55) op = OP_INTERN;
         else if (roll < 90) op = OP_FIND;
         else if (roll < 96) op = OP_RSVD;
         else op = OP_CLEAR;
         send_command(op, ($urandom_range(3) == 0) ? 25 : 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      words_sent = 0;
      results_seen = 0;
      mismatches = 0;
      clears_sent = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      key_hash_acc = FNV_BASIS;
      key_len = 0;
      key_long = 1'b0;
      tbl_count = 0;
      for (int i = 0; i < NSLOTS; i++) tbl_used[i] = 1'b0;
      for (int p = 0; p < POOL; p++) begin
         pool_len[p] = (p < 4) ? $urandom_range(KEY_MAX - 2, POOL_LEN) : $urandom_range(6);
         for (int i = 0; i < POOL_LEN; i++) pool_bytes[p][i] = 8'($urandom);
      end
      send_idle = 33;
      recv_idle = 59;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_random(words_sent + RAND_WORDS / 3);
      // hold intake until every result is out
      wait_drained();
      send_idle = 59;
      recv_idle = 33;
      test_random(words_sent + RAND_WORDS / 3);
      send_idle = 0;
      recv_idle = 0;
      test_random(words_sent + RAND_WORDS / 3);
      wait_drained();

      $display("covered %0d words, %0d results, %0d clears, %0d mismatches",
         words_sent, results_seen, clears_sent, mismatches);
      $display("statuses ins/ref/found/miss/long/full: %0d %0d %0d %0d %0d %0d",
         status_seen[0], status_seen[1], status_seen[2], status_seen[3],
         status_seen[4], status_seen[5]);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb_key_intern_hash_table: PASS");
      end else begin
         $display("tb_key_intern_hash_table: FAIL");
      end
      $finish;
   end

endmodule
